[sv/pwsw_pkg.sv]
// shared types, constants and helpers for the pulse-width single-wire transmitter
package pwsw_pkg;

  // width of the segment down-counter
  localparam int unsigned TIME_W = 8;
  localparam int unsigned TIME_MAX = (1 << TIME_W) - 1;

  localparam int unsigned REG_W = 8;
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW       = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH      = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ONE_LOW        = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH       = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ZERO_STOP_HIGH = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_ONE_STOP_HIGH  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_LOW      = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_HIGH     = REG_IDX_W'(7);

  typedef logic [REG_W-1:0] reg_val_t;
  typedef reg_val_t [REG_COUNT-1:0] reg_file_t;

  // reset values, indexed by register index
  localparam reg_file_t REG_RESET = '{
    REG_W'(4),  REG_W'(14), REG_W'(21), REG_W'(16),
    REG_W'(8),  REG_W'(2),  REG_W'(3),  REG_W'(7)
  };

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRE_LO  = 3'd1,
    PH_PRE_HI  = 3'd2,
    PH_BIT_LO  = 3'd3,
    PH_BIT_HI  = 3'd4,
    PH_POST_LO = 3'd5,
    PH_POST_HI = 3'd6
  } phase_t;

  // one classified item in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  // queue status towards the front end
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // zero length reads as one tick, too long saturates to the counter
  function automatic logic [TIME_W-1:0] seg_len(input reg_val_t v);
    int unsigned vv;
    vv = int'(v);
    if (vv == 0) vv = 1;
    if (vv > TIME_MAX) vv = TIME_MAX;
    return vv[TIME_W-1:0];
  endfunction

endpackage

[sv/pwsw_front.sv]
// front end: takes input transactions, classifies them and queues them
module pwsw_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          byte_value,
  input  logic                first_byte,
  input  logic                last_byte,
  input  pwsw_pkg::q_status_t q_status,
  output logic                push,
  output pwsw_pkg::item_t     push_item
);
  import pwsw_pkg::*;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item.cmd        = cmd_t'(command);
    // byte fields only matter for a load
    push_item.byte_value = (cmd_t'(command) == CMD_LOAD) ? byte_value : '0;
    push_item.first_byte = (cmd_t'(command) == CMD_LOAD) && first_byte;
    push_item.last_byte  = (cmd_t'(command) == CMD_LOAD) && last_byte;
  end

endmodule

[sv/pwsw_queue.sv]
// two-entry queue between the front end and the line engine
module pwsw_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pwsw_pkg::item_t     push_item,
  input  logic                pop,
  output pwsw_pkg::item_t     pop_item,
  output pwsw_pkg::q_status_t q_status
);
  import pwsw_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  assign pop_item       = entries[rd_ptr];
  assign q_status.empty = (count == 2'd0);
  assign q_status.full  = (count == 2'd2);

endmodule

[sv/pwsw_back.sv]
// line engine: config registers, phase sequencer and output register
module pwsw_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwsw_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pwsw_pkg::REG_W-1:0]        cfg_data,
  input  pwsw_pkg::q_status_t               q_status,
  input  pwsw_pkg::item_t                   q_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              line_level,
  output logic                              busy_res,
  output logic                              accepted
);
  import pwsw_pkg::*;

  reg_file_t         regs;
  phase_t            phase, phase_next;
  logic [TIME_W-1:0] time_left, time_next, time_dec;
  logic [7:0]        shift_byte, shift_next;
  logic [2:0]        bit_index, idx_next, idx_inc;
  logic              break_after, brk_next;
  logic              busy, cur_bit, nxt_bit, lvl, acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_valid) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // take a queued item whenever the output register is free or draining
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  assign busy     = (phase != PH_IDLE);
  assign cur_bit  = shift_byte[bit_index];
  assign idx_inc  = 3'(bit_index + 3'd1);
  assign nxt_bit  = shift_byte[idx_inc];
  assign time_dec = (time_left != '0) ? TIME_W'(time_left - 1'b1) : time_left;

  always_comb begin
    phase_next = phase;
    time_next  = time_left;
    shift_next = shift_byte;
    idx_next   = bit_index;
    brk_next   = break_after;
    lvl        = 1'b1;
    acc        = 1'b0;
    if (q_item.cmd == CMD_LOAD) begin
      if (!busy) begin
        acc        = 1'b1;
        shift_next = q_item.byte_value;
        idx_next   = 3'd0;
        brk_next   = q_item.last_byte;
        lvl        = 1'b0;
        if (q_item.first_byte) begin
          phase_next = PH_PRE_LO;
          time_next  = seg_len(regs[REG_BREAK_LOW]);
        end else begin
          phase_next = PH_BIT_LO;
          time_next  = seg_len(q_item.byte_value[0] ? regs[REG_ONE_LOW]
                                                    : regs[REG_ZERO_LOW]);
        end
      end else begin
        lvl = !(phase == PH_PRE_LO || phase == PH_BIT_LO || phase == PH_POST_LO);
      end
    end else if (busy) begin
      lvl       = !(phase == PH_PRE_LO || phase == PH_BIT_LO || phase == PH_POST_LO);
      time_next = time_dec;
      if (time_dec == '0) begin
        case (phase)
          PH_PRE_LO: begin
            phase_next = PH_PRE_HI;
            time_next  = seg_len(regs[REG_BREAK_HIGH]);
          end
          PH_PRE_HI: begin
            phase_next = PH_BIT_LO;
            time_next  = seg_len(cur_bit ? regs[REG_ONE_LOW] : regs[REG_ZERO_LOW]);
          end
          PH_BIT_LO: begin
            phase_next = PH_BIT_HI;
            if (bit_index == LAST_BIT) begin
              time_next = seg_len(cur_bit ? regs[REG_ONE_STOP_HIGH]
                                          : regs[REG_ZERO_STOP_HIGH]);
            end else begin
              time_next = seg_len(cur_bit ? regs[REG_ONE_HIGH] : regs[REG_ZERO_HIGH]);
            end
          end
          PH_BIT_HI: begin
            if (bit_index != LAST_BIT) begin
              idx_next   = idx_inc;
              phase_next = PH_BIT_LO;
              time_next  = seg_len(nxt_bit ? regs[REG_ONE_LOW] : regs[REG_ZERO_LOW]);
            end else if (break_after) begin
              phase_next = PH_POST_LO;
              time_next  = seg_len(regs[REG_BREAK_LOW]);
            end else begin
              phase_next = PH_IDLE;
              time_next  = '0;
            end
          end
          PH_POST_LO: begin
            phase_next = PH_POST_HI;
            time_next  = seg_len(regs[REG_BREAK_HIGH]);
          end
          default: begin
            phase_next = PH_IDLE;
            time_next  = '0;
          end
        endcase
      end
    end else begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      time_left   <= '0;
      shift_byte  <= '0;
      bit_index   <= 3'd0;
      break_after <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        time_left   <= time_next;
        shift_byte  <= shift_next;
        bit_index   <= idx_next;
        break_after <= brk_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_level <= lvl;
      busy_res   <= (phase_next != PH_IDLE);
      accepted   <= acc;
    end
  end

`ifndef SYNTH
  a_idle_no_time: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> time_left == '0)
    else $error("idle phase with time left");

  a_busy_has_time: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> time_left != '0)
    else $error("active segment with zero time left");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> busy_res)
    else $error("accepted load but not busy");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> line_level)
    else $error("line low while idle");
`endif

endmodule

[sv/pulse_width_single_wire_tx.sv]
// top level of the pulse-width single-wire transmitter
// Single-wire pulse-width transmitter. Each input transaction is either a one
// microsecond tick or a byte load, and each gives exactly one result
// transaction carrying the line level, whether sending continues and whether
// a load was taken. A load while a byte or break is in flight is rejected.
// Bits go out lsb first as a low pulse then a high recovery; bit 7 uses the
// stop recovery, and first/last bytes get a break before/after. A zero
// length register counts as one tick. While in_stall is low one transaction is
// taken per clock cycle: the front end queues items into a two-entry queue,
// the line engine executes one queued item per cycle while out_stall is low
// and holds its result in an output register, so in_stall only rises once the
// queue fills behind a stalled output. Config writes are always ready and take
// effect the next cycle; write them only while the block is quiet.
module pulse_width_single_wire_tx (
  input  logic                           clk,
  input  logic                           rst,
  // input transactions
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic [7:0]                     byte_value,
  input  logic                           first_byte,
  input  logic                           last_byte,
  // result transactions
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           line_level,
  output logic                           busy_res,
  output logic                           accepted,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pwsw_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pwsw_pkg::REG_W-1:0]     cfg_data
);
  import pwsw_pkg::*;

  q_status_t q_status;
  item_t     push_item;
  item_t     pop_item;
  logic      push;
  logic      pop;

  // classify and queue incoming transactions
  pwsw_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .byte_value (byte_value),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .q_status   (q_status),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples the input side from a stalled output
  pwsw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // phase sequencer and result register
  pwsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .q_item     (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_level (line_level),
    .busy_res   (busy_res),
    .accepted   (accepted)
  );

endmodule
